/* rtl/core/pcdt_pkg.sv */
`default_nettype none

package pcdt_pkg;

    // fixed field widths of the channels
    localparam int SLOT_W     = 6;
    localparam int SLOT_COUNT = 2 ** SLOT_W;
    localparam int CNT_W      = 64;
    localparam int LANES      = 4;
    localparam int CFG_AW     = 2;

    // defaults for the top level parameters
    localparam int PORT_SLOTS_DEF   = 64;
    localparam int COUNTER_BITS_DEF = 64;

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_COUNTER_LIMIT = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_RESET_GUARD   = CFG_AW'(1);

    localparam logic [CNT_W-1:0] LIMIT_RESET = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] GUARD_RESET = {CNT_W{1'b0}};

    // lane order in every counter group
    localparam int LANE_IN_BYTES  = 0;
    localparam int LANE_OUT_BYTES = 1;
    localparam int LANE_IN_PKTS   = 2;
    localparam int LANE_OUT_PKTS  = 3;

    // classification of one report, carried through the queue
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              skip;
        logic              rend;
    } t_tag;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DIFF,
        BS_WRAP,
        BS_PICK,
        BS_SUM
    } t_bstate;

endpackage

`default_nettype wire

/* rtl/core/pcdt_intf.sv */
`default_nettype none

interface pcdt_in_if;
    logic                         valid;
    logic                         ready;
    logic [pcdt_pkg::SLOT_W-1:0]  port_slot;
    logic [pcdt_pkg::CNT_W-1:0]   raw_in_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   raw_out_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   raw_in_pkts;
    logic [pcdt_pkg::CNT_W-1:0]   raw_out_pkts;
    logic                         is_loopback;
    logic                         is_up;
    logic                         round_end;

    modport source (
        output valid, port_slot, raw_in_bytes, raw_out_bytes, raw_in_pkts, raw_out_pkts,
               is_loopback, is_up, round_end,
        input  ready
    );
    modport sink (
        input  valid, port_slot, raw_in_bytes, raw_out_bytes, raw_in_pkts, raw_out_pkts,
               is_loopback, is_up, round_end,
        output ready
    );
endinterface

interface pcdt_out_if;
    logic                         valid;
    logic                         ready;
    logic [pcdt_pkg::CNT_W-1:0]   delta_in_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   delta_out_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   delta_in_pkts;
    logic [pcdt_pkg::CNT_W-1:0]   delta_out_pkts;
    logic [pcdt_pkg::CNT_W-1:0]   sum_in_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   sum_out_bytes;
    logic [pcdt_pkg::CNT_W-1:0]   sum_in_pkts;
    logic [pcdt_pkg::CNT_W-1:0]   sum_out_pkts;
    logic                         skipped;
    logic                         round_done;

    modport source (
        output valid, delta_in_bytes, delta_out_bytes, delta_in_pkts, delta_out_pkts,
               sum_in_bytes, sum_out_bytes, sum_in_pkts, sum_out_pkts, skipped, round_done,
        input  ready
    );
    modport sink (
        input  valid, delta_in_bytes, delta_out_bytes, delta_in_pkts, delta_out_pkts,
               sum_in_bytes, sum_out_bytes, sum_in_pkts, sum_out_pkts, skipped, round_done,
        output ready
    );
endinterface

interface pcdt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pcdt_pkg::CFG_AW-1:0]  addr;
    logic [pcdt_pkg::CNT_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/pcdt_front.sv */
`default_nettype none

module pcdt_front #(
    parameter int PORT_SLOTS   = pcdt_pkg::PORT_SLOTS_DEF,
    parameter int COUNTER_BITS = pcdt_pkg::COUNTER_BITS_DEF
) (
    pcdt_in_if.sink                                        i_in,
    output logic                                           o_push_valid,
    input  logic                                           i_push_ready,
    output pcdt_pkg::t_tag                                 o_push_tag,
    output logic [pcdt_pkg::LANES-1:0][COUNTER_BITS-1:0]   o_push_raw
);

    logic w_slot_out;

    // slots past the table are treated like a down port
    assign w_slot_out = (32'(i_in.port_slot) >= PORT_SLOTS);

    assign o_push_tag.slot = i_in.port_slot;
    assign o_push_tag.skip = i_in.is_loopback || !i_in.is_up || w_slot_out;
    assign o_push_tag.rend = i_in.round_end;

    // drop counter bits above the configured counter width
    assign o_push_raw[pcdt_pkg::LANE_IN_BYTES]  = i_in.raw_in_bytes[COUNTER_BITS-1:0];
    assign o_push_raw[pcdt_pkg::LANE_OUT_BYTES] = i_in.raw_out_bytes[COUNTER_BITS-1:0];
    assign o_push_raw[pcdt_pkg::LANE_IN_PKTS]   = i_in.raw_in_pkts[COUNTER_BITS-1:0];
    assign o_push_raw[pcdt_pkg::LANE_OUT_PKTS]  = i_in.raw_out_pkts[COUNTER_BITS-1:0];

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

`default_nettype wire

/* rtl/core/pcdt_queue.sv */
`default_nettype none

module pcdt_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_push_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = pcdt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_valid      = (r_cnt != CW'(0));
    assign o_data       = r_mem[r_rp];

    assign w_wr = i_push && o_push_ready;
    assign w_rd = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? PW'(0) : r_wp + PW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? PW'(0) : r_rp + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pcdt_back.sv */
`default_nettype none

module pcdt_back #(
    parameter int PORT_SLOTS   = pcdt_pkg::PORT_SLOTS_DEF,
    parameter int COUNTER_BITS = pcdt_pkg::COUNTER_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_q_valid,
    output logic                                           o_q_pop,
    input  pcdt_pkg::t_tag                                 i_q_tag,
    input  logic [pcdt_pkg::LANES-1:0][COUNTER_BITS-1:0]   i_q_raw,
    input  logic [COUNTER_BITS-1:0]                        i_lim,
    input  logic [COUNTER_BITS-1:0]                        i_guard,
    pcdt_out_if.source                                     o_out
);

    localparam int LANES   = pcdt_pkg::LANES;
    localparam int CW      = pcdt_pkg::CNT_W;
    localparam int CB      = COUNTER_BITS;
    localparam int ENTRIES = (PORT_SLOTS < pcdt_pkg::SLOT_COUNT) ? PORT_SLOTS
                                                                 : pcdt_pkg::SLOT_COUNT;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    pcdt_pkg::t_bstate r_state, n_state;

    logic w_pop, w_diff, w_wrap, w_pick, w_load;

    // slot table: last counters per slot, seen bit per slot
    logic [LANES-1:0][CB-1:0] r_prev [ENTRIES];
    logic [ENTRIES-1:0]       r_seen;

    logic [AW-1:0]            w_idx;
    logic [AW-1:0]            w_cur_idx;

    pcdt_pkg::t_tag           r_tag;
    logic [LANES-1:0][CB-1:0] r_raw;
    logic [LANES-1:0][CB-1:0] r_old;
    logic                     r_hit;
    logic [LANES-1:0]         r_rng;
    logic [LANES-1:0]         r_ge;
    logic [LANES-1:0]         r_nle;
    logic [LANES-1:0][CB-1:0] r_diff;
    logic [LANES-1:0][CB-1:0] r_wrap;
    logic [LANES-1:0][CB-1:0] r_delta;

    logic [LANES-1:0][CW-1:0] r_sum;
    logic                     r_fro;
    logic [LANES-1:0][CW-1:0] w_sum_add;
    logic [LANES-1:0][CW-1:0] w_sum_rep;

    logic                     r_out_valid;
    logic [LANES-1:0][CW-1:0] r_out_delta;
    logic [LANES-1:0][CW-1:0] r_out_sum;
    logic                     r_out_skip;
    logic                     r_out_done;

    assign w_idx     = i_q_tag.slot[AW-1:0];
    assign w_cur_idx = r_tag.slot[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcdt_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = pcdt_pkg::BS_DIFF;
                end
            end
            pcdt_pkg::BS_DIFF: n_state = pcdt_pkg::BS_WRAP;
            pcdt_pkg::BS_WRAP: n_state = pcdt_pkg::BS_PICK;
            pcdt_pkg::BS_PICK: n_state = pcdt_pkg::BS_SUM;
            pcdt_pkg::BS_SUM: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = pcdt_pkg::BS_IDLE;
                end
            end
            default: n_state = pcdt_pkg::BS_IDLE;
        endcase
    end

    // stage strobes
    always_comb begin
        w_pop  = 1'b0;
        w_diff = 1'b0;
        w_wrap = 1'b0;
        w_pick = 1'b0;
        w_load = 1'b0;
        case (r_state)
            pcdt_pkg::BS_IDLE: w_pop  = i_q_valid;
            pcdt_pkg::BS_DIFF: w_diff = 1'b1;
            pcdt_pkg::BS_WRAP: w_wrap = 1'b1;
            pcdt_pkg::BS_PICK: w_pick = 1'b1;
            pcdt_pkg::BS_SUM:  w_load = !r_out_valid || o_out.ready;
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcdt_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot table access: read on pop, write back as the deltas are picked
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_old <= r_prev[w_idx];
        end
        if (w_pick && !r_tag.skip) begin
            r_prev[w_cur_idx] <= r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_pick && !r_tag.skip) begin
            r_seen[w_cur_idx] <= 1'b1;
        end
    end

    // per lane delta datapath
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_tag <= i_q_tag;
            r_raw <= i_q_raw;
            r_hit <= r_seen[w_idx];
        end
        for (int l = 0; l < LANES; l++) begin
            if (w_diff) begin
                r_rng[l]  <= (r_old[l] > i_lim) || (r_raw[l] > i_lim);
                r_ge[l]   <= (r_old[l] <= r_raw[l]);
                r_nle[l]  <= (r_raw[l] <= i_guard);
                r_diff[l] <= r_raw[l] - r_old[l];
            end
            if (w_wrap) begin
                // limit - old + new + 1, taken modulo the counter width
                r_wrap[l] <= r_diff[l] + i_lim + CB'(1);
            end
            if (w_pick) begin
                if (r_tag.skip || !r_hit || r_rng[l]) begin
                    r_delta[l] <= '0;
                end else if (r_ge[l]) begin
                    r_delta[l] <= r_diff[l];
                end else if ((r_wrap[l] > i_guard) && r_nle[l]) begin
                    // counter was reset rather than wrapped
                    r_delta[l] <= r_raw[l];
                end else begin
                    r_delta[l] <= r_wrap[l];
                end
            end
        end
    end

    // saturating round totals
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [CW:0] s;
            s = {1'b0, r_sum[l]} + {1'b0, CW'(r_delta[l])};
            w_sum_add[l] = s[CW] ? {CW{1'b1}} : s[CW-1:0];
            w_sum_rep[l] = (r_fro && !r_tag.skip) ? w_sum_add[l] : r_sum[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_fro       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_sum       <= r_tag.rend ? '0 : w_sum_rep;
                r_fro       <= r_fro || r_tag.rend;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int l = 0; l < LANES; l++) begin
                r_out_delta[l] <= CW'(r_delta[l]);
            end
            r_out_sum  <= w_sum_rep;
            r_out_skip <= r_tag.skip;
            r_out_done <= r_tag.rend;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.delta_in_bytes  = r_out_delta[pcdt_pkg::LANE_IN_BYTES];
    assign o_out.delta_out_bytes = r_out_delta[pcdt_pkg::LANE_OUT_BYTES];
    assign o_out.delta_in_pkts   = r_out_delta[pcdt_pkg::LANE_IN_PKTS];
    assign o_out.delta_out_pkts  = r_out_delta[pcdt_pkg::LANE_OUT_PKTS];
    assign o_out.sum_in_bytes    = r_out_sum[pcdt_pkg::LANE_IN_BYTES];
    assign o_out.sum_out_bytes   = r_out_sum[pcdt_pkg::LANE_OUT_BYTES];
    assign o_out.sum_in_pkts     = r_out_sum[pcdt_pkg::LANE_IN_PKTS];
    assign o_out.sum_out_pkts    = r_out_sum[pcdt_pkg::LANE_OUT_PKTS];
    assign o_out.skipped         = r_out_skip;
    assign o_out.round_done      = r_out_done;

endmodule

`default_nettype wire

/* rtl/core/port_counter_delta_table_unit.sv */
`default_nettype none

// Channel   Dir  Carries                                   Handshake
// i_cfg     in   addr (register index), data               valid/ready, ready always high
// i_in      in   slot, four raw counters, flags, round end valid/ready
// o_out     out  four deltas, four round sums, flags       valid/ready
//
// Each report passes through the back end in order: slot table read, difference,
// wrap sum, delta pick with table write, sum and result load, one step each.
// While a result waits on o_out, up to three more reports are taken: one held in
// the back end and two in the 2-word queue. Reset (i_rst_n low, synchronous)
// clears seen bits and round sums, sets the limit to all ones and the guard to zero;
// the counter table needs no clearing pass.

module port_counter_delta_table_unit #(
    parameter int PORT_SLOTS   = pcdt_pkg::PORT_SLOTS_DEF,
    parameter int COUNTER_BITS = pcdt_pkg::COUNTER_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcdt_cfg_if.sink   i_cfg,
    pcdt_in_if.sink    i_in,
    pcdt_out_if.source o_out
);

    localparam int LANES = pcdt_pkg::LANES;
    localparam int TW    = $bits(pcdt_pkg::t_tag);
    localparam int QW    = TW + LANES * COUNTER_BITS;

    logic [pcdt_pkg::CNT_W-1:0] r_counter_limit;
    logic [pcdt_pkg::CNT_W-1:0] r_reset_guard;
    logic [COUNTER_BITS-1:0]    w_lim;
    logic [COUNTER_BITS-1:0]    w_guard_raw;
    logic [COUNTER_BITS-1:0]    w_guard;

    logic                                 w_push_valid;
    logic                                 w_push_ready;
    pcdt_pkg::t_tag                       w_push_tag;
    logic [LANES-1:0][COUNTER_BITS-1:0]   w_push_raw;
    logic [QW-1:0]                        w_q_wdata;
    logic [QW-1:0]                        w_q_rdata;
    logic                                 w_q_valid;
    logic                                 w_q_pop;
    pcdt_pkg::t_tag                       w_q_tag;
    logic [LANES-1:0][COUNTER_BITS-1:0]   w_q_raw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_limit <= pcdt_pkg::LIMIT_RESET;
            r_reset_guard   <= pcdt_pkg::GUARD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                pcdt_pkg::REG_COUNTER_LIMIT: r_counter_limit <= i_cfg.data;
                pcdt_pkg::REG_RESET_GUARD:   r_reset_guard   <= i_cfg.data;
                default: begin
                    r_counter_limit <= r_counter_limit;
                end
            endcase
        end
    end

    // a zero guard falls back to the limit
    assign w_lim       = r_counter_limit[COUNTER_BITS-1:0];
    assign w_guard_raw = r_reset_guard[COUNTER_BITS-1:0];
    assign w_guard     = (w_guard_raw == '0) ? w_lim : w_guard_raw;

    pcdt_front #(
        .PORT_SLOTS   (PORT_SLOTS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_tag   (w_push_tag),
        .o_push_raw   (w_push_raw)
    );

    assign w_q_wdata = {w_push_tag, w_push_raw};

    pcdt_queue #(
        .W (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_data       (w_q_wdata),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_data       (w_q_rdata)
    );

    assign w_q_tag = pcdt_pkg::t_tag'(w_q_rdata[QW-1 -: TW]);
    assign w_q_raw = w_q_rdata[LANES*COUNTER_BITS-1:0];

    pcdt_back #(
        .PORT_SLOTS   (PORT_SLOTS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_tag   (w_q_tag),
        .i_q_raw   (w_q_raw),
        .i_lim     (w_lim),
        .i_guard   (w_guard),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
